// File: src/pixel_channel_mean_defines.svh
// Assertion macros used by the top level to check the channel-mean logic.
`ifndef PIXEL_CHANNEL_MEAN_DEFINES_SVH
`define PIXEL_CHANNEL_MEAN_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pcm_pkg.sv
// Package with the widths, constants and shared types of the channel-mean block.
package pcm_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 32;
  localparam int COUNT_W    = 25;
  localparam int MAX_PIXELS = 16777216;
  localparam int QUO_W      = 8;
  localparam int STEP_W     = $clog2(QUO_W);
  localparam int NUM_W      = SUM_W + 2;
  localparam int CHAN_N     = 3;
  localparam int CHAN_W     = $clog2(CHAN_N);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } pcm_state_t;

endpackage

// File: src/pcm_accum.sv
// Running channel sums, pixel count and dropped-pixel flag of one image.
module pcm_accum
  import pcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               add_en,
  input  logic               clear,
  input  logic [PIX_W-1:0]   blue,
  input  logic [PIX_W-1:0]   green,
  input  logic [PIX_W-1:0]   red,
  output logic [SUM_W-1:0]   sum_blue,
  output logic [SUM_W-1:0]   sum_green,
  output logic [SUM_W-1:0]   sum_red,
  output logic [COUNT_W-1:0] pixel_count,
  output logic               dropped
);

  logic [SUM_W-1:0]   sum_b_r, sum_b_nxt;
  logic [SUM_W-1:0]   sum_g_r, sum_g_nxt;
  logic [SUM_W-1:0]   sum_r_r, sum_r_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               drop_r, drop_nxt;
  logic               room;

  assign room = (count_r < COUNT_W'(MAX_PIXELS));

  always_comb begin
    sum_b_nxt = sum_b_r;
    sum_g_nxt = sum_g_r;
    sum_r_nxt = sum_r_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (clear) begin
      sum_b_nxt = '0;
      sum_g_nxt = '0;
      sum_r_nxt = '0;
      count_nxt = '0;
      drop_nxt  = 1'b0;
    end else if (add_en) begin
      // Once the count is full, pixels are discarded and only flagged.
      if (room) begin
        sum_b_nxt = sum_b_r + SUM_W'(blue);
        sum_g_nxt = sum_g_r + SUM_W'(green);
        sum_r_nxt = sum_r_r + SUM_W'(red);
        count_nxt = count_r + COUNT_W'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_b_r <= '0;
      sum_g_r <= '0;
      sum_r_r <= '0;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      sum_b_r <= sum_b_nxt;
      sum_g_r <= sum_g_nxt;
      sum_r_r <= sum_r_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign sum_blue    = sum_b_r;
  assign sum_green   = sum_g_r;
  assign sum_red     = sum_r_r;
  assign pixel_count = count_r;
  assign dropped     = drop_r;

endmodule

// File: src/pcm_divider.sv
// Restoring divider that forms one rounded channel mean, one quotient bit per cycle.
module pcm_divider
  import pcm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum,
  input  logic [COUNT_W-1:0] count,
  output div_stat_t          stat,
  output logic [QUO_W-1:0]   quotient
);

  logic [NUM_W-1:0]  rem_r, rem_nxt;
  logic [NUM_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              zero_r, zero_nxt;
  logic [NUM_W:0]    diff;
  logic              fits;

  // The mean never exceeds the largest byte, so the quotient has only QUO_W bits
  // and the divisor starts shifted up by QUO_W-1 places.
  assign diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign fits = !diff[NUM_W];

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    if (start) begin
      // Numerator 2*sum + count, divisor 2*count gives round half up.
      rem_nxt  = {1'b0, sum, 1'b0} + NUM_W'(count);
      dsh_nxt  = NUM_W'({count, 1'b0, {(QUO_W-1){1'b0}}});
      quo_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      zero_nxt = (count == '0);
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[NUM_W-1:0] : rem_r;
      quo_nxt  = {quo_r[QUO_W-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(QUO_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = zero_r ? '0 : quo_r;

endmodule

// File: src/pixel_channel_mean.sv
// Top level of the per-channel RGB mean block: handshakes, sequencer and output register.
//
// Each accepted item is one pixel; a pixel without in_tlast is summed in the cycle it
// is accepted, so such pixels stream at one per cycle. The pixel marked last is summed
// the same way and then the block drops in_tready while one shared 34-bit restoring
// divider, eight quotient bits per channel at one bit per cycle, forms the blue, green
// and red means in turn (round half up). Each channel passes through a start cycle,
// eight quotient steps and a capture cycle, and then the emit state loads the output
// register, staying there for as long as an earlier result still waits to be taken.
// The result item carries the three means and an overflow flag that is set when more
// than 16777216 pixels arrived and the extra ones were dropped. The sums clear when
// the result is loaded into the output register, which holds it until taken; the next
// image can start streaming while that result waits.
`include "pixel_channel_mean_defines.svh"

module pixel_channel_mean
  import pcm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue_in [7:0], green_in [15:8], red_in [23:16]
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mean_blue [7:0], mean_green [15:8], mean_red [23:16]
  output logic        out_tuser   // overflow
);

  pcm_state_t         state_r, state_nxt;
  logic [CHAN_W-1:0]  chan_r, chan_nxt;
  logic [QUO_W-1:0]   means_r [CHAN_N];
  logic [23:0]        out_data_r;
  logic               out_user_r;
  logic               out_valid_r, out_valid_nxt;

  logic               in_acc;
  logic               div_start;
  logic               cap_q;
  logic               emit_go;
  logic               last_chan;
  div_stat_t          div_stat;
  logic [QUO_W-1:0]   quotient;
  logic [SUM_W-1:0]   sum_b, sum_g, sum_r, sum_sel;
  logic [COUNT_W-1:0] acc_count;
  logic               dropped;

  assign in_acc    = in_tvalid && in_tready;
  assign last_chan = (chan_r == CHAN_W'(CHAN_N-1));

  pcm_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .add_en      (in_acc),
    .clear       (emit_go),
    .blue        (in_tdata[7:0]),
    .green       (in_tdata[15:8]),
    .red         (in_tdata[23:16]),
    .sum_blue    (sum_b),
    .sum_green   (sum_g),
    .sum_red     (sum_r),
    .pixel_count (acc_count),
    .dropped     (dropped)
  );

  always_comb begin
    case (chan_r)
      CHAN_W'(0): sum_sel = sum_b;
      CHAN_W'(1): sum_sel = sum_g;
      default:    sum_sel = sum_r;
    endcase
  end

  pcm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_sel),
    .count    (acc_count),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) state_nxt = ST_DIV_START;
      end
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = last_chan ? ST_EMIT : ST_DIV_START;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    cap_q     = 1'b0;
    emit_go   = 1'b0;
    case (state_r)
      ST_IDLE:      in_tready = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  cap_q     = div_stat.done;
      ST_EMIT:      emit_go   = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    chan_nxt = chan_r;
    if (cap_q) chan_nxt = last_chan ? '0 : chan_r + CHAN_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_q) means_r[chan_r] <= quotient;
    if (emit_go) begin
      out_data_r <= {means_r[2], means_r[1], means_r[0]};
      out_user_r <= dropped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PCM_ASSERT_SAME(a_out_from_emit, $rose(out_tvalid), $past(state_r == ST_EMIT), "stray result")
  `PCM_ASSERT_SAME(a_div_done_waited, div_stat.done, state_r == ST_DIV_WAIT, "divider done early")
  `PCM_ASSERT_SAME(a_busy_in_wait, div_stat.busy, state_r == ST_DIV_WAIT, "busy outside wait")
  `PCM_ASSERT_NEXT(a_clear_after_emit, emit_go, acc_count == '0 && !dropped, "sums not cleared")
  `PCM_ASSERT_SAME(a_count_bound, 1'b1, acc_count <= COUNT_W'(MAX_PIXELS), "count over limit")

endmodule
